>>> src/ctg_pkg.sv
// Shared types, constants and tables for the circle trajectory generator.
// Depends on nothing; the sequencer, the datapath and the top module import it.
`timescale 1ns / 1ps

package ctg_pkg;

  localparam int FIELD_W        = 32;   // position fields, Q16.16
  localparam int CFG_W          = 32;   // widest register
  localparam int CFG_IDX_W      = 3;
  localparam int RADIUS_W       = 31;
  localparam int ANGLE_W        = 32;   // 2^32 is one full turn
  localparam int PHASE_BITS_DEF = 32;
  localparam int POS_BITS_DEF   = 32;

  localparam int CORDIC_STEPS = 24;
  localparam int ITER_W       = $clog2(CORDIC_STEPS);
  localparam int VEC_W        = 34;     // Q2.30 vector and residual angle, with headroom
  localparam int ATAN_W       = 30;
  localparam int FRAC_SHIFT   = 30;

  localparam logic signed [VEC_W-1:0] CORDIC_GAIN = 34'sd652032874;

  // arctangent of 2^-i, angle word units
  localparam logic [ATAN_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43, 30'h0145D7E1,
    30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F, 30'h000A2F98, 30'h000517CC,
    30'h00028BE6, 30'h000145F3, 30'h0000A2FA, 30'h0000517D, 30'h000028BE, 30'h0000145F,
    30'h00000A30, 30'h00000518, 30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PHASE_STEP = 3'd0,
    REG_RADIUS     = 3'd1,
    REG_CENTER_X   = 3'd2,
    REG_CENTER_Y   = 3'd3,
    REG_CENTER_Z   = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_ROT,
    S_MUL_S,
    S_MUL_C,
    S_RND,
    S_SUM
  } ctg_state_t;

  typedef struct packed {
    logic restart;
  } in_item_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] pos_x;
    logic signed [FIELD_W-1:0] pos_y;
    logic signed [FIELD_W-1:0] pos_z;
  } out_item_t;

  typedef struct packed {
    logic phase_clear;
    logic phase_adv;
    logic cordic_load;
    logic cordic_step;
    logic mul_load;
    logic mul_cos;
    logic rnd_x;
    logic rnd_y;
    logic out_load;
  } ctg_cmd_t;

  typedef struct packed {
    logic iter_last;
    logic out_free;
  } ctg_status_t;

endpackage

>>> src/ctg_stream_if.sv
// Valid/ready stream channel with a typed payload.
// Payload types come from ctg_pkg at the point of instantiation.
`timescale 1ns / 1ps

interface ctg_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> src/ctg_ctrl.sv
// Sequencer for the circle trajectory generator: accepts ticks and steps the datapath.
// Depends on ctg_pkg and ctg_stream_if.
`timescale 1ns / 1ps

module ctg_ctrl
  import ctg_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  ctg_stream_if.sink   in_ch,
  input  ctg_status_t  status,
  output ctg_cmd_t     cmd
);

  ctg_state_t state, state_next;
  logic       idle;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_ch.valid && !in_ch.data.restart) state_next = S_LOAD;
      end
      S_LOAD:  state_next = S_ROT;
      S_ROT: begin
        if (status.iter_last) state_next = S_MUL_S;
      end
      S_MUL_S: state_next = S_MUL_C;
      S_MUL_C: state_next = S_RND;
      S_RND:   state_next = S_SUM;
      S_SUM: begin
        if (status.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    idle = 1'b0;
    unique case (state)
      S_IDLE: begin
        idle            = 1'b1;
        cmd.phase_clear = in_ch.valid && in_ch.data.restart;
        cmd.phase_adv   = in_ch.valid && !in_ch.data.restart;
      end
      S_LOAD:  cmd.cordic_load = 1'b1;
      S_ROT:   cmd.cordic_step = 1'b1;
      S_MUL_S: cmd.mul_load    = 1'b1;
      S_MUL_C: begin
        cmd.mul_load = 1'b1;
        cmd.mul_cos  = 1'b1;
        cmd.rnd_x    = 1'b1;
      end
      S_RND:   cmd.rnd_y    = 1'b1;
      S_SUM:   cmd.out_load = status.out_free;
      default: cmd = '0;
    endcase
  end

  assign in_ch.ready = idle;

endmodule

>>> src/ctg_datapath.sv
// Datapath: config registers, phase accumulator, iterative CORDIC, scaling and output register.
// Depends on ctg_pkg and ctg_stream_if; driven by ctg_ctrl commands.
`timescale 1ns / 1ps

module ctg_datapath
  import ctg_pkg::*;
#(
  parameter int PHASE_BITS = PHASE_BITS_DEF,
  parameter int POS_BITS   = POS_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  ctg_cmd_t             cmd,
  output ctg_status_t          status,
  ctg_stream_if.source         out_ch
);

  localparam int WIDE_W  = PHASE_BITS + ANGLE_W;
  localparam int PROD_W  = RADIUS_W + 1 + VEC_W;
  localparam int D_W     = PROD_W - FRAC_SHIFT;
  localparam int SUM_W   = ((D_W > POS_BITS) ? D_W : POS_BITS) + 1;
  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(64'sd1 <<< (FRAC_SHIFT - 1));
  localparam logic signed [SUM_W-1:0]  POS_HI     = SUM_W'((64'sd1 <<< (POS_BITS - 1)) - 1);
  localparam logic signed [SUM_W-1:0]  POS_LO     = -POS_HI - SUM_W'(1);

  // configuration registers
  logic [CFG_W-1:0]           phase_step;
  logic [RADIUS_W-1:0]        radius;
  logic signed [FIELD_W-1:0]  center_x;
  logic signed [FIELD_W-1:0]  center_y;
  logic signed [FIELD_W-1:0]  center_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= '0;
      radius     <= '0;
      center_x   <= '0;
      center_y   <= '0;
      center_z   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PHASE_STEP: phase_step <= cfg_data;
        REG_RADIUS:     radius     <= cfg_data[RADIUS_W-1:0];
        REG_CENTER_X:   center_x   <= cfg_data;
        REG_CENTER_Y:   center_y   <= cfg_data;
        REG_CENTER_Z:   center_z   <= cfg_data;
        default: ;
      endcase
    end
  end

  // phase accumulator, wraps at 2^PHASE_BITS
  logic [PHASE_BITS-1:0] phase;
  logic [WIDE_W-1:0]     phase_wide;
  logic [ANGLE_W-1:0]    angle;
  logic [ANGLE_W-1:0]    angle_fold;
  logic                  fold;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (cmd.phase_clear) begin
      phase <= '0;
    end else if (cmd.phase_adv) begin
      phase <= phase + PHASE_BITS'(phase_step);
    end
  end

  // align to the 32-bit angle word: truncate extra low bits or zero-fill
  assign phase_wide = {phase, ANGLE_W'(0)} >> PHASE_BITS;
  assign angle      = phase_wide[ANGLE_W-1:0];
  // second and third quadrants: rotate by a half turn, negate at the end
  assign fold       = angle[ANGLE_W-1] ^ angle[ANGLE_W-2];
  assign angle_fold = {angle[ANGLE_W-1] ^ fold, angle[ANGLE_W-2:0]};

  // CORDIC rotation, one iteration per cycle
  logic signed [VEC_W-1:0] cx, cy, cz;
  logic signed [VEC_W-1:0] cx_sh, cy_sh, atan_v;
  logic [ITER_W-1:0]       idx;
  logic                    neg;

  assign cx_sh  = cx >>> idx;
  assign cy_sh  = cy >>> idx;
  assign atan_v = {{(VEC_W-ATAN_W){1'b0}}, ATAN_TAB[idx]};

  always_ff @(posedge clk) begin
    if (cmd.cordic_load) begin
      cx  <= CORDIC_GAIN;
      cy  <= '0;
      cz  <= {{(VEC_W-ANGLE_W){angle_fold[ANGLE_W-1]}}, angle_fold};
      neg <= fold;
      idx <= '0;
    end else if (cmd.cordic_step) begin
      if (!cz[VEC_W-1]) begin
        cx <= cx - cy_sh;
        cy <= cy + cx_sh;
        cz <= cz - atan_v;
      end else begin
        cx <= cx + cy_sh;
        cy <= cy - cx_sh;
        cz <= cz + atan_v;
      end
      idx <= idx + ITER_W'(1);
    end
  end

  assign status.iter_last = (idx == ITER_W'(CORDIC_STEPS - 1));

  // radius scaling: one shared multiplier, sine then cosine
  logic signed [VEC_W-1:0]    mul_op, mul_op_n;
  logic signed [RADIUS_W:0]   radius_s;
  logic signed [PROD_W-1:0]   prod, prod_next, prod_rnd, prod_sh;
  logic signed [D_W-1:0]      dx, dy;

  assign mul_op    = cmd.mul_cos ? cx : cy;
  assign mul_op_n  = neg ? -mul_op : mul_op;
  assign radius_s  = {1'b0, radius};
  assign prod_next = PROD_W'(radius_s) * PROD_W'(mul_op_n);
  // round half up to Q16.16
  assign prod_rnd  = prod + ROUND_HALF;
  assign prod_sh   = prod_rnd >>> FRAC_SHIFT;

  always_ff @(posedge clk) begin
    if (cmd.mul_load) prod <= prod_next;
    if (cmd.rnd_x)    dx   <= prod_sh[D_W-1:0];
    if (cmd.rnd_y)    dy   <= prod_sh[D_W-1:0];
  end

  // coordinate sums with saturation to the position range
  function automatic logic [FIELD_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] r;
    begin
      if (v > POS_HI) begin
        r = POS_HI;
      end else if (v < POS_LO) begin
        r = POS_LO;
      end else begin
        r = v;
      end
      return r[FIELD_W-1:0];
    end
  endfunction

  logic signed [SUM_W-1:0] sum_x, sum_y, sum_z;
  out_item_t               out_data;
  logic                    out_valid;

  assign sum_x = SUM_W'(center_x) + SUM_W'(dx);
  assign sum_y = SUM_W'(center_y) + SUM_W'(dy);
  assign sum_z = SUM_W'(center_z);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.pos_x <= sat_pos(sum_x);
      out_data.pos_y <= sat_pos(sum_y);
      out_data.pos_z <= sat_pos(sum_z);
    end
  end

  assign status.out_free = !out_valid || out_ch.ready;
  assign out_ch.valid    = out_valid;
  assign out_ch.data     = out_data;

endmodule

>>> src/circle_trajectory_generator.sv
// Circle trajectory generator: each normal tick advances the phase and emits one point.
// Sequence: after its transfer a normal tick goes through a load, 24 CORDIC
// iterations on a single shift-add unit, 2 multiplies, round and sum; the sum
// waits while the output register still holds an untaken point.
// A new tick is taken only back in idle; a restart is taken in idle and stays there.
// Reset (rst, synchronous, active high) clears registers, phase and output valid.
`timescale 1ns / 1ps

module circle_trajectory_generator
  import ctg_pkg::*;
#(
  parameter int PHASE_BITS = PHASE_BITS_DEF,  // phase accumulator width, one turn is 2^PHASE_BITS
  parameter int POS_BITS   = POS_BITS_DEF     // saturation range of the coordinates
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  ctg_stream_if.sink           in_ch,   // payload in_item_t
  ctg_stream_if.source         out_ch   // payload out_item_t
);

  // Command and status between sequencer and datapath.
  ctg_cmd_t    cmd;
  ctg_status_t status;

  // Sequencer: takes a tick only when idle. A restart transfer clears the
  // phase in the same cycle; a normal tick advances it and starts the rotation.
  ctg_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .status (status),
    .cmd    (cmd)
  );

  // Datapath: the output register holds a finished point until its transfer,
  // so the sequencer may take the next tick and start the next rotation.
  ctg_datapath #(
    .PHASE_BITS (PHASE_BITS),
    .POS_BITS   (POS_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_ch    (out_ch)
  );

`ifndef SYNTH
  // A normal tick starts the rotation in the next cycle.
  a_start: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready && !in_ch.data.restart) |=> cmd.cordic_load)
    else $error("rotation did not start after a tick transfer");

  // Leaving the rotation goes straight to the sine multiply.
  a_rot_exit: assert property (@(posedge clk) disable iff (rst)
    (cmd.cordic_step && status.iter_last) |=> (cmd.mul_load && !cmd.mul_cos))
    else $error("sine multiply did not follow the last iteration");

  // No datapath work while the input side is open.
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> (!cmd.cordic_step && !cmd.mul_load && !cmd.out_load))
    else $error("datapath busy while ready");

  // A pending point is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_ch.valid || out_ch.ready))
    else $error("output register overwritten before transfer");
`endif

endmodule
